// ----- design/assert_macros.svh -----
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define CHK_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define CHK_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define CHK_NEXT_ALWAYS(label, clk, pre, post, msg) \
    label: assert property (@(posedge clk) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- design/dtci_pkg.sv -----
// ----------------------------------------------------------------------------
// Debug tether command interpreter package
// Sizes, command codes, register indices and reply encoding helpers.
// ----------------------------------------------------------------------------
package dtci_pkg;

    localparam int STACK_DEPTH   = 10;
    localparam int MEM_BYTES     = 1024;
    localparam int MAX_BURST_OUT = 64;

    localparam int ADDR_W    = $clog2(MEM_BYTES);
    localparam int BCNT_W    = $clog2(MAX_BURST_OUT + 1);
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [7:0] END_BYTE = 8'hC0;

    localparam logic [DATA_W-1:0] SCRATCH_A_RESET = 32'd0;
    localparam logic [DATA_W-1:0] SCRATCH_B_RESET = 32'd64;

    localparam logic [DATA_W-1:0] NUM_LIM1 = 32'h40;
    localparam logic [DATA_W-1:0] NUM_LIM2 = 32'd2000;
    localparam logic [DATA_W-1:0] NUM_LIM3 = 32'd100000;
    localparam logic [DATA_W-1:0] NUM_LIM4 = 32'd8000000;

    localparam logic [CFG_IDX_W-1:0] CFG_SCRATCH_A = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCRATCH_B = 1'd1;

    localparam logic [4:0] CMD_NOP    = 5'd0;
    localparam logic [4:0] CMD_RD_W   = 5'd1;
    localparam logic [4:0] CMD_RD_H   = 5'd2;
    localparam logic [4:0] CMD_RD_B   = 5'd3;
    localparam logic [4:0] CMD_WR_W   = 5'd4;
    localparam logic [4:0] CMD_WR_H   = 5'd5;
    localparam logic [4:0] CMD_WR_B   = 5'd6;
    localparam logic [4:0] CMD_SEND   = 5'd7;
    localparam logic [4:0] CMD_EXIT   = 5'd8;
    localparam logic [4:0] CMD_SCR_A  = 5'd9;
    localparam logic [4:0] CMD_SCR_B  = 5'd10;
    localparam logic [4:0] CMD_BWRITE = 5'd11;
    localparam logic [4:0] CMD_BREAD  = 5'd12;
    localparam logic [4:0] CMD_PING   = 5'd13;

    // Number of continuation bytes that follow the lead byte of a number.
    function automatic logic [2:0] num_cont(input logic [DATA_W-1:0] u);
        logic [2:0] c;
        if (u < NUM_LIM1) begin
            c = 3'd0;
        end else if (u < NUM_LIM2) begin
            c = 3'd1;
        end else if (u < NUM_LIM3) begin
            c = 3'd2;
        end else if (u < NUM_LIM4) begin
            c = 3'd3;
        end else begin
            c = 3'd4;
        end
        return c;
    endfunction

    // Seven-bit digit of a number, least significant digit at index zero.
    function automatic logic [6:0] num_digit(input logic [DATA_W-1:0] u,
                                             input logic [2:0] idx);
        logic [6:0] d;
        case (idx)
            3'd0:    d = u[6:0];
            3'd1:    d = u[13:7];
            3'd2:    d = u[20:14];
            3'd3:    d = u[27:21];
            default: d = {3'b000, u[31:28]};
        endcase
        return d;
    endfunction

endpackage

// ----- design/debug_tether_command_interpreter_core.sv -----
// ----------------------------------------------------------------------------
// Debug tether command interpreter core
// Decodes host bytes into digit, literal and command beats, keeps the value
// stack and the target memory, and sends reply bytes back to the host.
//
//   Channel   Direction  Handshake          Payload
//   input     in         i_valid / o_stall  i_rx_byte
//   output    out        o_valid / i_stall  o_tx_byte, o_last_of_run
//   config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
// After reset a clearing pass writes zeros to all 1024 memory bytes, one per
// cycle, and the input stays stalled until the clearing pass is done.
// Digit, literal, burst data and stack commands are taken in the idle state.
// Reads fetch through the registered read, then send one reply byte per cycle;
// writes take one cycle per byte through the single memory write port.
// A burst read passes each byte through an address state and a data state.
// A stall on the output holds the reply sequencer; the input stays stalled
// until the last reply byte has entered the output register.
// ----------------------------------------------------------------------------
module debug_tether_command_interpreter_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dtci_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dtci_pkg::DATA_W-1:0]       i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [7:0]                        i_rx_byte,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [7:0]                        o_tx_byte,
    output logic                              o_last_of_run
);

    localparam int AW = dtci_pkg::ADDR_W;
    localparam int BW = dtci_pkg::BCNT_W;
    localparam int DW = dtci_pkg::DATA_W;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_RD    = 10'b0000000100,
        S_WR    = 10'b0000001000,
        S_PREP  = 10'b0000010000,
        S_LEAD  = 10'b0000100000,
        S_CONT  = 10'b0001000000,
        S_END   = 10'b0010000000,
        S_BRD_A = 10'b0100000000,
        S_BRD_D = 10'b1000000000
    } t_state;

    t_state          r_state, n_state;
    logic [DW-1:0]   r_stack [dtci_pkg::STACK_DEPTH];
    logic [DW-1:0]   n_stack [dtci_pkg::STACK_DEPTH];
    logic [DW-1:0]   r_scr_a, n_scr_a;
    logic [DW-1:0]   r_scr_b, n_scr_b;
    logic            r_halted, n_halted;
    logic [DW-1:0]   r_brem, n_brem;
    logic [AW-1:0]   r_bptr, n_bptr;
    logic [AW-1:0]   r_clr, n_clr;
    logic [2:0]      r_k, n_k;
    logic [2:0]      r_nb, n_nb;
    logic [DW-1:0]   r_acc, n_acc;
    logic [DW-1:0]   r_num, n_num;
    logic [BW-1:0]   r_bi, n_bi;
    logic [BW-1:0]   r_bn, n_bn;
    logic            r_ov, n_ov;
    logic [7:0]      r_otx, n_otx;
    logic            r_olast, n_olast;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;

    logic            accept;
    logic            out_free;
    logic            brd_last;
    logic [4:0]      cmd;

    dtci_ram #(
        .WIDTH (8),
        .DEPTH (dtci_pkg::MEM_BYTES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_ov || !i_stall;
    assign cmd      = i_rx_byte[4:0];
    assign brd_last = (BW'(r_bi + 1'b1) == r_bn);

    always_comb begin
        n_state  = r_state;
        n_stack  = r_stack;
        n_scr_a  = r_scr_a;
        n_scr_b  = r_scr_b;
        n_halted = r_halted;
        n_brem   = r_brem;
        n_bptr   = r_bptr;
        n_clr    = r_clr;
        n_k      = r_k;
        n_nb     = r_nb;
        n_acc    = r_acc;
        n_num    = r_num;
        n_bi     = r_bi;
        n_bn     = r_bn;
        n_ov     = r_ov && i_stall;
        n_otx    = r_otx;
        n_olast  = r_olast;

        ram_we    = 1'b0;
        ram_waddr = r_bptr;
        ram_wdata = i_rx_byte;
        ram_raddr = r_stack[0][AW-1:0] + AW'(r_k);

        if (i_cfg_we) begin
            case (i_cfg_index)
                dtci_pkg::CFG_SCRATCH_A: n_scr_a = i_cfg_data;
                dtci_pkg::CFG_SCRATCH_B: n_scr_b = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = 8'h00;
                n_clr     = r_clr + 1'b1;
                if (r_clr == AW'(dtci_pkg::MEM_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (accept) begin
                    if (r_brem != '0) begin
                        ram_we = 1'b1;
                        n_bptr = r_bptr + 1'b1;
                        n_brem = r_brem - 1'b1;
                    end else if (!r_halted) begin
                        if (!i_rx_byte[7]) begin
                            n_stack[0] = {r_stack[0][DW-8:0], i_rx_byte[6:0]};
                        end else if (!i_rx_byte[6]) begin
                            for (int i = 1; i < dtci_pkg::STACK_DEPTH; i++) begin
                                n_stack[i] = r_stack[i-1];
                            end
                            n_stack[0] = {{(DW-6){1'b0}}, i_rx_byte[5:0]};
                        end else if (i_rx_byte[5]) begin
                            n_state = S_END;
                        end else begin
                            n_k   = 3'd0;
                            n_acc = '0;
                            case (cmd)
                                dtci_pkg::CMD_RD_W: begin
                                    n_nb    = 3'd4;
                                    n_state = S_RD;
                                end
                                dtci_pkg::CMD_RD_H: begin
                                    n_nb    = 3'd2;
                                    n_state = S_RD;
                                end
                                dtci_pkg::CMD_RD_B: begin
                                    n_nb    = 3'd1;
                                    n_state = S_RD;
                                end
                                dtci_pkg::CMD_WR_W: begin
                                    n_nb    = 3'd4;
                                    n_state = S_WR;
                                end
                                dtci_pkg::CMD_WR_H: begin
                                    n_nb    = 3'd2;
                                    n_state = S_WR;
                                end
                                dtci_pkg::CMD_WR_B: begin
                                    n_nb    = 3'd1;
                                    n_state = S_WR;
                                end
                                dtci_pkg::CMD_SEND: begin
                                    n_num   = r_stack[0];
                                    n_state = S_PREP;
                                end
                                dtci_pkg::CMD_EXIT: begin
                                    n_halted = 1'b1;
                                end
                                dtci_pkg::CMD_SCR_A, dtci_pkg::CMD_SCR_B: begin
                                    for (int i = 1; i < dtci_pkg::STACK_DEPTH; i++) begin
                                        n_stack[i] = r_stack[i-1];
                                    end
                                    n_stack[0] = (cmd == dtci_pkg::CMD_SCR_A) ? r_scr_a
                                                                              : r_scr_b;
                                end
                                dtci_pkg::CMD_BWRITE: begin
                                    n_bptr = r_stack[1][AW-1:0];
                                    n_brem = r_stack[0];
                                end
                                dtci_pkg::CMD_BREAD: begin
                                    n_bi = '0;
                                    if (r_stack[0] < DW'(dtci_pkg::MAX_BURST_OUT)) begin
                                        n_bn = r_stack[0][BW-1:0];
                                    end else begin
                                        n_bn = BW'(dtci_pkg::MAX_BURST_OUT);
                                    end
                                    if (r_stack[0] != '0) begin
                                        n_state = S_BRD_A;
                                    end
                                end
                                dtci_pkg::CMD_PING: begin
                                    n_state = S_END;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
            end

            S_RD: begin
                case (r_k)
                    3'd1:    n_acc[7:0]   = ram_rdata;
                    3'd2:    n_acc[15:8]  = ram_rdata;
                    3'd3:    n_acc[23:16] = ram_rdata;
                    3'd4:    n_acc[31:24] = ram_rdata;
                    default: ;
                endcase
                n_k = r_k + 1'b1;
                if (r_k == r_nb) begin
                    n_stack[0] = n_acc;
                    n_num      = n_acc;
                    n_state    = S_PREP;
                end
            end

            S_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_stack[0][AW-1:0] + AW'(r_k);
                case (r_k)
                    3'd0:    ram_wdata = r_stack[1][7:0];
                    3'd1:    ram_wdata = r_stack[1][15:8];
                    3'd2:    ram_wdata = r_stack[1][23:16];
                    default: ram_wdata = r_stack[1][31:24];
                endcase
                n_k = r_k + 1'b1;
                if (r_k == r_nb - 1'b1) begin
                    n_state = S_IDLE;
                end
            end

            S_PREP: begin
                n_k     = dtci_pkg::num_cont(r_num);
                n_state = S_LEAD;
            end

            S_LEAD: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_otx   = {1'b1, dtci_pkg::num_digit(r_num, r_k)};
                    n_olast = 1'b0;
                    if (r_k == 3'd0) begin
                        n_state = S_END;
                    end else begin
                        n_k     = r_k - 1'b1;
                        n_state = S_CONT;
                    end
                end
            end

            S_CONT: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_otx   = {1'b0, dtci_pkg::num_digit(r_num, r_k)};
                    n_olast = 1'b0;
                    if (r_k == 3'd0) begin
                        n_state = S_END;
                    end else begin
                        n_k = r_k - 1'b1;
                    end
                end
            end

            S_END: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_otx   = dtci_pkg::END_BYTE;
                    n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_BRD_A: begin
                ram_raddr = r_stack[1][AW-1:0] + AW'(r_bi);
                n_state   = S_BRD_D;
            end

            S_BRD_D: begin
                ram_raddr = r_stack[1][AW-1:0] + AW'(r_bi);
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_otx   = ram_rdata;
                    n_olast = brd_last;
                    n_bi    = r_bi + 1'b1;
                    n_state = brd_last ? S_IDLE : S_BRD_A;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            for (int i = 0; i < dtci_pkg::STACK_DEPTH; i++) begin
                r_stack[i] <= '0;
            end
            r_scr_a  <= dtci_pkg::SCRATCH_A_RESET;
            r_scr_b  <= dtci_pkg::SCRATCH_B_RESET;
            r_halted <= 1'b0;
            r_brem   <= '0;
            r_bptr   <= '0;
            r_clr    <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_stack  <= n_stack;
            r_scr_a  <= n_scr_a;
            r_scr_b  <= n_scr_b;
            r_halted <= n_halted;
            r_brem   <= n_brem;
            r_bptr   <= n_bptr;
            r_clr    <= n_clr;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_nb    <= n_nb;
        r_acc   <= n_acc;
        r_num   <= n_num;
        r_bi    <= n_bi;
        r_bn    <= n_bn;
        r_otx   <= n_otx;
        r_olast <= n_olast;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_ov;
    assign o_tx_byte     = r_otx;
    assign o_last_of_run = r_olast;

endmodule

// ----- design/dtci_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dtci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/dtci_checker.sv -----
// ----------------------------------------------------------------------------
// Debug tether command interpreter checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtci_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_tx_byte,
    input logic       o_last_of_run
);

    // A stalled output beat stays offered and unchanged.
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_tx_byte) && $stable(o_last_of_run), "stalled output beat changed")

    // While a reply run is incomplete, no new host byte is taken.
    `CHK_IMPL(a_run_blocks_input, i_clk, i_rst_n, o_valid && !o_last_of_run, o_stall, "input taken during an incomplete reply run")

    // The memory clearing pass holds the input off straight after reset.
    `CHK_NEXT_ALWAYS(a_clear_after_reset, i_clk, !i_rst_n, o_stall && !o_valid, "input not held off after reset")

endmodule

bind debug_tether_command_interpreter_core dtci_checker u_dtci_checker (.*);
